@@ src/lmcce_pkg.sv @@
// shared types, register indexes and byte classification for the escaper
package lmcce_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 17;
	localparam int unsigned IdxW    = 3;
	localparam int unsigned HoldW   = 2;
	localparam int unsigned SlotW   = 2;

	localparam logic [ByteW-1:0] ChNul   = 8'd0;
	localparam logic [ByteW-1:0] ChTab   = 8'd9;
	localparam logic [ByteW-1:0] ChLf    = 8'd10;
	localparam logic [ByteW-1:0] ChSpace = 8'd32;
	localparam logic [ByteW-1:0] ChZero  = 8'd48;
	localparam logic [ByteW-1:0] ChDel   = 8'd127;
	localparam logic [LenW-1:0]  Reserve = 17'd3;

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_ESCAPE_CHAR      = 3'd0,
		REG_ESCAPE_CONTROL   = 3'd1,
		REG_LF_TO_SPACE      = 3'd2,
		REG_ESCAPE_HIGH      = 3'd3,
		REG_ESCAPE_TAB       = 3'd4,
		REG_DROP_TRAILING_LF = 3'd5,
		REG_MAX_LINE         = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] escape_char;
		logic             escape_control;
		logic             lf_to_space;
		logic             escape_high;
		logic             escape_tab;
		logic             drop_trailing_lf;
		logic [LenW-1:0]  max_line;
	} cfg_t;

	// source bytes of one word to be written out, oldest first
	typedef struct packed {
		logic [2:0][ByteW-1:0] bytes;
		logic [SlotW-1:0]      n;
		logic                  last;
	} job_t;

	// byte after optional line feed mapping
	function automatic logic [ByteW-1:0] map_byte(input logic [ByteW-1:0] c, input cfg_t cfg);
		logic [ByteW-1:0] r;
		r = c;
		if (cfg.lf_to_space && c == ChLf) begin
			r = ChSpace;
		end
		return r;
	endfunction

	// true when a mapped byte goes out as an octal escape
	function automatic logic needs_escape(input logic [ByteW-1:0] c, input cfg_t cfg);
		logic ctl;
		logic hi;
		ctl = (c < ChSpace) && (c != ChTab || cfg.escape_tab) &&
		      (c == ChNul || cfg.escape_control);
		hi  = (c > ChDel) && cfg.escape_high;
		return ctl || hi;
	endfunction

endpackage

@@ src/lmcce_if.sv @@
// valid/ready channels for raw message bytes and sanitized result words
interface lmcce_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in;

	modport source (output valid, output data_byte, output last_in, input ready);
	modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface lmcce_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;
	logic       no_byte;

	modport source (output valid, output out_byte, output last_out, output no_byte, input ready);
	modport sink   (input valid, input out_byte, input last_out, input no_byte, output ready);
endinterface

@@ src/log_message_control_char_escaper_unit.sv @@
// Log message control character escaper: takes one byte word a cycle while the emitter is ready,
// writes escaped words. A source byte passes the job register and then the output register
// once the word that releases it from the two-byte trailing hold is taken; escape digits follow
// one per cycle while the output is ready. Each released byte costs one output word (four when
// escaped), input waits meanwhile, so the output port sets the rate. At most 12 words per word.
// Reset: arst_n clears the hold, counters and handshakes and loads register defaults.
module log_message_control_char_escaper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [16:0] wr_data,
	lmcce_in_if.sink    msg_in,
	lmcce_out_if.source msg_out
);

	lmcce_pkg::cfg_t                    cfg_q;
	logic [1:0][lmcce_pkg::ByteW-1:0]   held_q;
	logic [lmcce_pkg::HoldW-1:0]        held_cnt_q;

	logic                               acc;
	logic                               job_push;
	logic                               job_ready;
	lmcce_pkg::job_t                    job;
	logic [2:0][lmcce_pkg::ByteW-1:0]   buf_b;
	logic [lmcce_pkg::SlotW-1:0]        n0;
	logic [lmcce_pkg::SlotW-1:0]        n1;
	logic [lmcce_pkg::ByteW-1:0]        tail;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_char      <= 8'd35;
			cfg_q.escape_control   <= 1'b1;
			cfg_q.lf_to_space      <= 1'b0;
			cfg_q.escape_high      <= 1'b0;
			cfg_q.escape_tab       <= 1'b1;
			cfg_q.drop_trailing_lf <= 1'b1;
			cfg_q.max_line         <= 17'd8096;
		end else if (wr_en) begin
			case (lmcce_pkg::reg_idx_t'(wr_index))
				lmcce_pkg::REG_ESCAPE_CHAR:      cfg_q.escape_char      <= wr_data[7:0];
				lmcce_pkg::REG_ESCAPE_CONTROL:   cfg_q.escape_control   <= wr_data[0];
				lmcce_pkg::REG_LF_TO_SPACE:      cfg_q.lf_to_space      <= wr_data[0];
				lmcce_pkg::REG_ESCAPE_HIGH:      cfg_q.escape_high      <= wr_data[0];
				lmcce_pkg::REG_ESCAPE_TAB:       cfg_q.escape_tab       <= wr_data[0];
				lmcce_pkg::REG_DROP_TRAILING_LF: cfg_q.drop_trailing_lf <= wr_data[0];
				lmcce_pkg::REG_MAX_LINE:         cfg_q.max_line         <= wr_data;
				default: ;
			endcase
		end
	end

	assign msg_in.ready = job_ready;
	assign acc          = msg_in.valid && job_ready;

	// message tail with the new byte appended, then trailing trim
	always_comb begin
		buf_b[0] = (held_cnt_q == 2'd0) ? msg_in.data_byte : held_q[0];
		buf_b[1] = (held_cnt_q == 2'd1) ? msg_in.data_byte : held_q[1];
		buf_b[2] = msg_in.data_byte;
		n0 = held_cnt_q + 2'd1;
		if (msg_in.data_byte == lmcce_pkg::ChNul) begin
			n0 = held_cnt_q;
		end
		case (n0)
			2'd1:    tail = buf_b[0];
			2'd2:    tail = buf_b[1];
			2'd3:    tail = buf_b[2];
			default: tail = '0;
		endcase
		n1 = n0;
		if (cfg_q.drop_trailing_lf && n0 != 2'd0 && tail == lmcce_pkg::ChLf) begin
			n1 = n0 - 2'd1;
		end
	end

	// job built from the word: release the oldest held byte, or the whole trimmed tail
	always_comb begin
		job.bytes = buf_b;
		job.n     = n1;
		job.last  = msg_in.last_in;
		job_push  = acc && msg_in.last_in;
		if (!msg_in.last_in) begin
			job.bytes = {held_q[1], held_q[1], held_q[0]};
			job.n     = 2'd1;
			job_push  = acc && held_cnt_q == 2'd2;
		end
	end

	// trailing hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
		end else if (acc) begin
			if (msg_in.last_in) begin
				held_cnt_q <= '0;
			end else if (held_cnt_q != 2'd2) begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !msg_in.last_in) begin
			if (held_cnt_q == 2'd2) begin
				held_q[0] <= held_q[1];
				held_q[1] <= msg_in.data_byte;
			end else if (held_cnt_q == 2'd1) begin
				held_q[1] <= msg_in.data_byte;
			end else begin
				held_q[0] <= msg_in.data_byte;
			end
		end
	end

	lmcce_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_push  (job_push),
		.job_in    (job),
		.job_ready (job_ready),
		.out_ch    (msg_out)
	);

endmodule

@@ src/lmcce_emitter.sv @@
// walks the source bytes of one job, expanding escapes and applying the length limit
module lmcce_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  lmcce_pkg::cfg_t     cfg,
	input  logic                job_push,
	input  lmcce_pkg::job_t     job_in,
	output logic                job_ready,
	lmcce_out_if.source         out_ch
);

	logic                                job_valid_q;
	lmcce_pkg::job_t                     job_q;
	logic [lmcce_pkg::SlotW-1:0]         idx_q;
	logic [1:0]                          sub_q;
	logic                                emitted_q;
	logic [lmcce_pkg::LenW-1:0]          count_q;
	logic                                trunc_q;
	logic                                out_valid_q;
	logic [lmcce_pkg::ByteW-1:0]         out_byte_q;
	logic                                out_last_q;
	logic                                out_nob_q;

	logic                                adv;
	logic [lmcce_pkg::ByteW-1:0]         raw;
	logic [lmcce_pkg::ByteW-1:0]         c2;
	logic                                esc;
	logic [lmcce_pkg::LenW-1:0]          lim;
	logic                                cut;
	logic                                have;
	logic                                byte_end;
	logic                                done;
	logic                                emit;
	logic [lmcce_pkg::ByteW-1:0]         ch;
	logic [lmcce_pkg::LenW:0]            count_inc;
	logic [lmcce_pkg::SlotW-1:0]         idx_inc;

	// current source byte
	always_comb begin
		case (idx_q)
			2'd0:    raw = job_q.bytes[0];
			2'd1:    raw = job_q.bytes[1];
			2'd2:    raw = job_q.bytes[2];
			default: raw = '0;
		endcase
	end

	// limit test and escape decision
	always_comb begin
		lim       = (cfg.max_line >= lmcce_pkg::Reserve) ? (cfg.max_line - lmcce_pkg::Reserve) : '0;
		cut       = trunc_q || (count_q >= lim);
		c2        = lmcce_pkg::map_byte(raw, cfg);
		esc       = lmcce_pkg::needs_escape(c2, cfg);
		have      = (idx_q != job_q.n) && !(sub_q == 2'd0 && cut);
		byte_end  = !esc || sub_q == 2'd3;
		count_inc = {1'b0, count_q} + 18'd1;
		idx_inc   = idx_q + 2'd1;
		adv       = job_valid_q && (!out_valid_q || out_ch.ready);
	end

	// character selection and end of job
	always_comb begin
		ch   = '0;
		emit = 1'b0;
		done = 1'b0;
		if (have) begin
			emit = 1'b1;
			done = byte_end && ((idx_inc == job_q.n) || (count_inc >= {1'b0, lim}));
			case (sub_q)
				2'd0:    ch = esc ? cfg.escape_char : c2;
				2'd1:    ch = lmcce_pkg::ChZero + {6'd0, c2[7:6]};
				2'd2:    ch = lmcce_pkg::ChZero + {5'd0, c2[5:3]};
				2'd3:    ch = lmcce_pkg::ChZero + {5'd0, c2[2:0]};
				default: ch = '0;
			endcase
		end else begin
			// empty close of a last job that wrote nothing
			emit = job_q.last && !emitted_q;
			done = 1'b1;
		end
	end

	assign job_ready = !job_valid_q || (adv && done);

	// job and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			sub_q       <= '0;
			emitted_q   <= 1'b0;
			count_q     <= '0;
			trunc_q     <= 1'b0;
		end else begin
			if (adv) begin
				if (done) begin
					idx_q     <= '0;
					sub_q     <= '0;
					emitted_q <= 1'b0;
					if (job_q.last) begin
						count_q <= '0;
						trunc_q <= 1'b0;
					end else if (have) begin
						count_q <= count_inc[lmcce_pkg::LenW-1:0];
					end else if (cut && idx_q != job_q.n) begin
						trunc_q <= 1'b1;
					end
				end else begin
					count_q   <= count_inc[lmcce_pkg::LenW-1:0];
					emitted_q <= 1'b1;
					if (byte_end) begin
						idx_q <= idx_inc;
						sub_q <= '0;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
			end
			if (job_ready) begin
				job_valid_q <= job_push;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (job_ready && job_push) begin
			job_q <= job_in;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q <= ch;
			out_last_q <= done && job_q.last;
			out_nob_q  <= !have;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last_out = out_last_q;
	assign out_ch.no_byte  = out_nob_q;

endmodule
